// File: design/sus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sus_pkg: shared codes for the sorted unique key set
// Command and status codes and the field and word widths of both streams.
// ----------------------------------------------------------------------------
package sus_pkg;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_ERASE  = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_ABSENT = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  localparam int CmdW    = 3;
  localparam int KeyW    = 32;
  localparam int PosW    = 4;
  localparam int CountW  = 5;
  localparam int StatusW = 3;
  localparam int CapW    = 5;

  localparam int InW  = 40;
  localparam int OutW = 48;

  localparam logic [CapW-1:0] CapReset = 5'd16;

endpackage

// File: design/sorted_unique_key_set_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_key_set_top: bounded set of unique keys in ascending order
// Keys are ordered by their byte-reversed value. A sequencer scans and shifts
// the entries of one synchronous key memory to insert, erase, find and read.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      cmd, key, position
//  m_axis    out  m_axis_tvalid/tready      present, read_value, entry_count, status
//  cfg       in   cfg_wr_en                 capacity_limit
//
//  One command at a time. The scan compares entries from the lowest up until one
//  matches or passes the key or the count is reached. A successful insert or erase
//  then shifts the entries past the slot, a read fetches one entry, then the result posts.
//  The scan and the shift walk the key memory one entry per cycle.
//  Reset clears the count at once; entries at or above the count are never used.
//  A result that waits on m_axis_tready holds the next command at the post step.
// ----------------------------------------------------------------------------
module sorted_unique_key_set_top #(
  parameter int DEPTH     = 16,
  parameter int KEY_BYTES = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [2:0] cmd, [34:3] key, [38:35] position, [39] zero
  input  logic [sus_pkg::InW-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] present, [32:1] read_value, [37:33] entry_count, [40:38] status,
  // [47:41] zero
  output logic [sus_pkg::OutW-1:0]  m_axis_tdata,
  input  logic                      cfg_wr_en,
  input  logic [sus_pkg::CapW-1:0]  cfg_wr_data
);
  import sus_pkg::*;

  localparam int KB = (KEY_BYTES < 4) ? KEY_BYTES : 4;
  localparam int KW = 8 * KB;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SEARCH   = 7'b0000010,
    S_DISPATCH = 7'b0000100,
    S_SHIFT_UP = 7'b0001000,
    S_SHIFT_DN = 7'b0010000,
    S_READ     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  function automatic logic [KW-1:0] order_of(input logic [KW-1:0] v);
    logic [KW-1:0] r;
    r = '0;
    for (int b = 0; b < KB; b++) begin
      r[8*(KB-1-b) +: 8] = v[8*b +: 8];
    end
    return r;
  endfunction

  logic [KW-1:0] mem [DEPTH];
  logic [KW-1:0] rdata;
  logic          we;
  logic [AW-1:0] wa;
  logic [KW-1:0] wd;
  logic [AW-1:0] ra;

  state_t        state, state_next;
  logic [CapW-1:0] cap;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] slot, slot_next;
  logic          hit, hit_next;
  cmd_t          cmd, cmd_next;
  logic [KW-1:0] key, key_next;
  logic [PosW-1:0] pos, pos_next;
  logic [KW-1:0] value, value_next;
  status_t       status, status_next;

  logic            out_valid, out_valid_next;
  logic [OutW-1:0] out_word, out_word_next;

  logic full;
  logic in_range;

  assign full = (32'(count) >= 32'(cap)) || (32'(count) >= 32'(DEPTH));
  assign in_range = 32'(pos) < 32'(count);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    slot_next      = slot;
    hit_next       = hit;
    cmd_next       = cmd;
    key_next       = key;
    pos_next       = pos;
    value_next     = value;
    status_next    = status;
    out_valid_next = out_valid && !m_axis_tready;
    out_word_next  = out_word;
    we = 1'b0;
    wa = '0;
    wd = '0;
    ra = '0;

    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_next    = cmd_t'(s_axis_tdata[CmdW-1:0]);
          key_next    = s_axis_tdata[CmdW +: KW];
          pos_next    = s_axis_tdata[CmdW+KeyW +: PosW];
          value_next  = '0;
          status_next = ST_OK;
          ptr_next    = '0;
          state_next  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // rdata holds the entry at ptr
        if (ptr == count) begin
          hit_next   = 1'b0;
          slot_next  = ptr;
          state_next = S_DISPATCH;
        end else if (order_of(rdata) == order_of(key)) begin
          hit_next   = 1'b1;
          slot_next  = ptr;
          state_next = S_DISPATCH;
        end else if (order_of(rdata) > order_of(key)) begin
          hit_next   = 1'b0;
          slot_next  = ptr;
          state_next = S_DISPATCH;
        end else begin
          ptr_next = ptr + CW'(1);
          ra       = AW'(ptr + CW'(1));
        end
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        case (cmd)
          CMD_INSERT: begin
            if (full) begin
              status_next = ST_FULL;
            end else if (hit) begin
              status_next = ST_DUP;
            end else begin
              ptr_next   = count;
              ra         = AW'(count - CW'(1));
              state_next = S_SHIFT_UP;
            end
          end
          CMD_ERASE: begin
            if (!hit) begin
              status_next = ST_ABSENT;
            end else begin
              ptr_next   = slot;
              ra         = AW'(slot + CW'(1));
              state_next = S_SHIFT_DN;
            end
          end
          CMD_FIND: begin
            status_next = hit ? ST_OK : ST_ABSENT;
          end
          CMD_READ: begin
            ra         = AW'(pos);
            state_next = S_READ;
          end
          CMD_CLEAR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_UP: begin
        we = 1'b1;
        wa = AW'(ptr);
        if (ptr == slot) begin
          wd         = key;
          count_next = count + CW'(1);
          state_next = S_DONE;
        end else begin
          // rdata holds the entry below ptr; move it up one place
          wd       = rdata;
          ra       = AW'(ptr - CW'(2));
          ptr_next = ptr - CW'(1);
        end
      end
      S_SHIFT_DN: begin
        if (32'(ptr) + 32'd1 >= 32'(count)) begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end else begin
          we       = 1'b1;
          wa       = AW'(ptr);
          wd       = rdata;
          ra       = AW'(ptr + CW'(2));
          ptr_next = ptr + CW'(1);
        end
      end
      S_READ: begin
        if (in_range) begin
          value_next = rdata;
        end else begin
          status_next = ST_RANGE;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_word_next  = {7'd0, status, CountW'(count), KeyW'(value), hit};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= CapReset;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    slot     <= slot_next;
    hit      <= hit_next;
    cmd      <= cmd_next;
    key      <= key_next;
    pos      <= pos_next;
    value    <= value_next;
    status   <= status_next;
    out_word <= out_word_next;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(DEPTH))
    else $error("key count exceeds storage depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accepting a word");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_UP && ptr == slot) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not add one key");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[40:38] == ST_RANGE) |-> (m_axis_tdata[32:1] == 32'd0))
    else $error("out of range read returned a nonzero value");

  a_result_stable_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !m_axis_tready) |=> (state == S_DONE))
    else $error("result posted over a waiting word");
`endif

endmodule
